// ===== sv/pfri_pkg.sv =====
package pfri_pkg;

    // width of one input lane
    localparam int DATA_W = 32;
    // cycles through the constant reducer
    localparam int RED_LAT = 3;
    // cycles per exponent bit: product register plus reducer
    localparam int STEP_LAT = RED_LAT + 1;

    typedef enum logic {
        CMD_REDUCE  = 1'b0,
        CMD_INVERSE = 1'b1
    } cmd_t;

endpackage

// ===== sv/pfri_modred.sv =====
// x mod P for a 32-bit x, Barrett style: quotient estimate, back-multiply, one fix-up.
module pfri_modred import pfri_pkg::*; #(
    parameter int P  = 4093,
    parameter int PW = 12
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [DATA_W-1:0] x,
    output logic [PW-1:0]     res
);

    localparam int K  = DATA_W + PW;
    localparam int MW = DATA_W + 2;
    localparam logic [63:0] MU64 = (64'd1 << K) / P;
    localparam logic [MW-1:0] MU = MU64[MW-1:0];
    localparam int QW = DATA_W + MW - K;
    localparam logic [DATA_W-1:0] PD = DATA_W'(P);
    localparam logic [PW:0] PR = (PW+1)'(P);

    logic [DATA_W+MW-1:0] prod_reg;
    logic [DATA_W-1:0]    x1_reg, x2_reg, qp_reg;
    logic [PW-1:0]        res_reg;
    logic [QW-1:0]        q;
    logic [DATA_W-1:0]    diff;
    logic [PW:0]          r;

    assign q    = prod_reg[DATA_W+MW-1:K];
    assign diff = x2_reg - qp_reg;
    assign r    = diff[PW:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (DATA_W+MW)'(x) * (DATA_W+MW)'(MU);
            x1_reg   <= x;
            qp_reg   <= DATA_W'(DATA_W'(q) * PD);
            x2_reg   <= x1_reg;
            res_reg  <= (r >= PR) ? PW'(r - PR) : PW'(r);
        end
    end

    assign res = res_reg;

endmodule

// ===== sv/pfri_lane.sv =====
// One lane: reduce, then one square-and-multiply step per exponent bit, LSB first.
module pfri_lane import pfri_pkg::*; #(
    parameter int P  = 4093,
    parameter int PW = 12
) (
    input  logic              aclk,
    input  logic              en,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] x,
    output logic [PW-1:0]     res
);

    localparam logic [PW-1:0] EXP = PW'(P - 2);
    localparam int TAIL = STEP_LAT * PW;

    logic [PW-1:0] base_s [0:PW];
    logic [PW-1:0] acc_s  [0:PW];
    cmd_t          cmd_d_reg [0:RED_LAT-1];
    cmd_t          cmd_t_reg [0:TAIL-1];
    logic [PW-1:0] r0_reg    [0:TAIL-1];

    pfri_modred #(.P(P), .PW(PW)) u_red0 (
        .aclk (aclk), .en (en), .x (x), .res (base_s[0])
    );
    assign acc_s[0] = PW'(1);

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_d_reg[0] <= cmd;
            for (int i = 1; i < RED_LAT; i++) cmd_d_reg[i] <= cmd_d_reg[i-1];
            cmd_t_reg[0] <= cmd_d_reg[RED_LAT-1];
            r0_reg[0]    <= base_s[0];
            for (int i = 1; i < TAIL; i++) begin
                cmd_t_reg[i] <= cmd_t_reg[i-1];
                r0_reg[i]    <= r0_reg[i-1];
            end
        end
    end

    for (genvar b = 0; b < PW; b++) begin : g_step
        logic [2*PW-1:0] sq_reg;

        always_ff @(posedge aclk) begin
            if (en) sq_reg <= (2*PW)'(base_s[b]) * (2*PW)'(base_s[b]);
        end

        pfri_modred #(.P(P), .PW(PW)) u_sq (
            .aclk (aclk), .en (en), .x (DATA_W'(sq_reg)), .res (base_s[b+1])
        );

        if (EXP[b]) begin : g_mul
            logic [2*PW-1:0] mu_reg;

            always_ff @(posedge aclk) begin
                if (en) mu_reg <= (2*PW)'(acc_s[b]) * (2*PW)'(base_s[b]);
            end

            pfri_modred #(.P(P), .PW(PW)) u_mu (
                .aclk (aclk), .en (en), .x (DATA_W'(mu_reg)), .res (acc_s[b+1])
            );
        end else begin : g_pass
            logic [PW-1:0] dly_reg [0:STEP_LAT-1];

            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[0] <= acc_s[b];
                    for (int i = 1; i < STEP_LAT; i++) dly_reg[i] <= dly_reg[i-1];
                end
            end
            assign acc_s[b+1] = dly_reg[STEP_LAT-1];
        end
    end

    assign res = (cmd_t_reg[TAIL-1] == CMD_INVERSE) ? acc_s[PW] : r0_reg[TAIL-1];

endmodule

// ===== sv/prime_field_reduce_and_inverse.sv =====
// Lane-parallel prime field unit. Each item carries LANE_COUNT unsigned 32-bit lanes
// (s_tdata) and a command (s_tuser): reduce every lane mod PRIME_MODULUS, or return
// its field inverse x^(p-2) mod p (zero inverts to zero). Results are exact residues
// 0..p-1, FIELD_BITS wide per lane. The unit is a pipeline: a Barrett reducer on the
// input, then one square per exponent bit and one multiply per set bit (a delay line
// for a clear bit), each square or multiply a multiplier register followed by a
// three-stage reducer. It takes one item per cycle; the whole pipeline holds only
// while a result waits at m_tvalid with m_tready low. Reduce items travel the same
// pipeline, so results leave in input order. No configuration, no state.
module prime_field_reduce_and_inverse import pfri_pkg::*; #(
    parameter int PRIME_MODULUS = 4093,
    parameter int FIELD_BITS    = 12,
    parameter int LANE_COUNT    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lane_in_0 .. lane_in_N, 32 bits each, lane 0 lowest
    input  logic [LANE_COUNT*DATA_W-1:0] s_tdata,
    // cmd
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lane_out_0 .. lane_out_N, FIELD_BITS each, lane 0 lowest, zero pad to bytes
    output logic [((LANE_COUNT*FIELD_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int PW    = $clog2(PRIME_MODULUS);
    localparam int LAT   = RED_LAT + STEP_LAT * PW;
    localparam int OUT_W = ((LANE_COUNT*FIELD_BITS+7)/8)*8;
    localparam int PAD   = OUT_W - LANE_COUNT*FIELD_BITS;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LANE_COUNT*FIELD_BITS-1:0] packed_res;

    // pipeline moves unless a finished item is stalled at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];

    for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
        logic [PW-1:0] lane_res;

        pfri_lane #(.P(PRIME_MODULUS), .PW(PW)) u_lane (
            .aclk (aclk),
            .en   (en),
            .cmd  (cmd_t'(s_tuser)),
            .x    (s_tdata[l*DATA_W +: DATA_W]),
            .res  (lane_res)
        );
        // merge: lanes packed side by side
        assign packed_res[l*FIELD_BITS +: FIELD_BITS] = FIELD_BITS'(lane_res);
    end

    if (PAD > 0) begin : g_pad
        assign m_tdata = {{PAD{1'b0}}, packed_res};
    end else begin : g_nopad
        assign m_tdata = packed_res;
    end

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow output stall");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_lane0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[FIELD_BITS-1:0] < FIELD_BITS'(PRIME_MODULUS)
                      || PW > FIELD_BITS))
        else $error("lane 0 result not reduced");
`endif

endmodule
